@@ sv/atomic_memory_operation_unit_assert.svh @@
// Assertion macros for the atomic memory operation unit checker.
`ifndef ATOMIC_MEMORY_OPERATION_UNIT_ASSERT_SVH
`define ATOMIC_MEMORY_OPERATION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define AMO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define AMO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/amo_pkg.sv @@
`timescale 1ns / 1ps

package amo_pkg;

   localparam int DEFAULT_WORDS = 1024;
   localparam int DATA_W        = 32;
   localparam int INDEX_W       = 10;

   typedef enum logic [2:0] {
      OP_LOAD         = 3'd0,
      OP_STORE        = 3'd1,
      OP_FETCH_ADD    = 3'd2,
      OP_SWAP         = 3'd3,
      OP_COMPARE_SWAP = 3'd4,
      OP_BIT_SET      = 3'd5,
      OP_BIT_CLEAR    = 3'd6,
      OP_INVALID      = 3'd7
   } op_type;

   typedef struct packed {
      op_type              req_type;
      logic [INDEX_W-1:0]  word_index;
      logic [DATA_W-1:0]   operand;
      logic [DATA_W-1:0]   expected;
   } amo_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   old_value;
      logic                success;
   } amo_rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic                success;
      logic [DATA_W-1:0]   next_value;
      logic [DATA_W-1:0]   old_value;
   } amo_alu_result_type;

endpackage

@@ sv/atomic_memory_operation_unit.sv @@
`timescale 1ns / 1ps

// Atomic memory unit over a store of WORDS 32-bit words, all zero after reset.
// A request is taken when start is high and busy is low; each request is one
// store read, then the modify and write back in ST_EXEC through the single
// store port, so busy is high in the cycle after each transfer and a new
// request cannot be taken until the unit returns to ST_IDLE. The result
// appears on rsp_payload with rsp_valid high for exactly one cycle, registered
// in ST_EXEC after the store read, and must be captured then: the receiver
// cannot stall. After reset the unit zeroes the store one word a cycle,
// holding busy high until every word is cleared, before any request is taken.
module atomic_memory_operation_unit #(
   parameter int WORDS = amo_pkg::DEFAULT_WORDS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  amo_pkg::amo_req_type req_payload,
   output logic                 rsp_valid,
   output amo_pkg::amo_rsp_type rsp_payload
);
   import amo_pkg::*;

   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   state_type          state_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic [AW-1:0]      addr_ff;
   op_type             op_ff;
   logic [DATA_W-1:0]  operand_ff;
   logic [DATA_W-1:0]  expected_ff;
   logic               in_range_ff;
   logic               rsp_valid_ff;
   amo_rsp_type        rsp_payload_ff;

   logic               accept;
   logic               req_in_range;
   logic [AW-1:0]      req_addr;
   logic [AW-1:0]      mem_addr;
   logic               mem_wr_en;
   logic [DATA_W-1:0]  mem_wr_data;
   logic [DATA_W-1:0]  mem_rd_data;
   amo_alu_result_type alu_res;

   assign busy         = reset || (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign req_in_range = 32'(req_payload.word_index) < 32'(WORDS);
   assign req_addr     = AW'(req_payload.word_index);

   always_comb begin
      case (state_ff)
         ST_CLEAR: mem_addr = clr_addr_ff;
         ST_EXEC:  mem_addr = addr_ff;
         default:  mem_addr = req_addr;
      endcase
   end

   assign mem_wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_EXEC) && alu_res.wr_en);
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : alu_res.next_value;

   amo_store #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (accept),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   amo_alu u_alu (
      .op       (op_ff),
      .in_range (in_range_ff),
      .prior    (mem_rd_data),
      .operand  (operand_ff),
      .expected (expected_ff),
      .result   (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               rsp_valid_ff <= 1'b0;
               clr_addr_ff  <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  addr_ff     <= req_addr;
                  op_ff       <= req_payload.req_type;
                  operand_ff  <= req_payload.operand;
                  expected_ff <= req_payload.expected;
                  in_range_ff <= req_in_range;
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_valid_ff             <= 1'b1;
               rsp_payload_ff.old_value <= alu_res.old_value;
               rsp_payload_ff.success   <= alu_res.success;
               state_ff                 <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ sv/amo_store.sv @@
`timescale 1ns / 1ps

module amo_store #(
   parameter int WORDS = amo_pkg::DEFAULT_WORDS,
   parameter int AW    = amo_pkg::INDEX_W
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic                       wr_en,
   input  logic [AW-1:0]              addr,
   input  logic [amo_pkg::DATA_W-1:0] wr_data,
   output logic [amo_pkg::DATA_W-1:0] rd_data
);
   import amo_pkg::*;

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/amo_alu.sv @@
`timescale 1ns / 1ps

module amo_alu (
   input  amo_pkg::op_type             op,
   input  logic                        in_range,
   input  logic [amo_pkg::DATA_W-1:0]  prior,
   input  logic [amo_pkg::DATA_W-1:0]  operand,
   input  logic [amo_pkg::DATA_W-1:0]  expected,
   output amo_pkg::amo_alu_result_type result
);
   import amo_pkg::*;

   logic              wr_en;
   logic              success;
   logic [DATA_W-1:0] next_value;

   always_comb begin
      wr_en      = 1'b1;
      success    = 1'b1;
      next_value = prior;
      case (op)
         OP_LOAD: begin
            wr_en = 1'b0;
         end
         OP_STORE, OP_SWAP: begin
            next_value = operand;
         end
         OP_FETCH_ADD: begin
            next_value = prior + operand;
         end
         OP_COMPARE_SWAP: begin
            if (prior == expected) begin
               next_value = operand;
            end else begin
               wr_en   = 1'b0;
               success = 1'b0;
            end
         end
         OP_BIT_SET: begin
            next_value = prior | operand;
         end
         OP_BIT_CLEAR: begin
            next_value = prior & ~operand;
         end
         default: begin
            wr_en   = 1'b0;
            success = 1'b0;
         end
      endcase
   end

   assign result.wr_en      = wr_en & in_range;
   assign result.success    = success & in_range;
   assign result.next_value = next_value;
   assign result.old_value  = in_range ? prior : '0;

endmodule

@@ sv/amo_checker.sv @@
`timescale 1ns / 1ps
`include "atomic_memory_operation_unit_assert.svh"

module amo_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input amo_pkg::amo_req_type req_payload,
   input logic                 rsp_valid,
   input amo_pkg::amo_rsp_type rsp_payload
);
   import amo_pkg::*;

   logic req_xfer;
   logic bad_op;

   assign req_xfer = start && !busy;
   assign bad_op   = req_payload.req_type == OP_INVALID;

   `AMO_ASSERT_NEXT(a_busy_after_xfer, req_xfer, busy, "busy low after a request transfer")
   `AMO_ASSERT_NEXT(a_rsp_follows, req_xfer, ##1 rsp_valid, "no result two cycles after transfer")
   `AMO_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held for two cycles")
   `AMO_ASSERT_NOW(a_rsp_after_busy, rsp_valid, $past(busy), "result without a busy cycle before")
   `AMO_ASSERT_NEXT(a_bad_op_fails, req_xfer && bad_op, ##1 !rsp_payload.success,
      "unknown operation reported success")

endmodule

bind atomic_memory_operation_unit amo_checker u_amo_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
